[sv/csf_pkg.sv]
// ----------------------------------------------------------------------------
// csf_pkg
// Shared types, register codes and the case fold for the caseless substring
// finder.
// ----------------------------------------------------------------------------
package csf_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 64;
    localparam int POS_W       = 16;
    localparam int LEN_REG_W   = 5;
    // needle bytes beyond this count read as zero
    localparam int NEEDLE_REG_BYTES = 16;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_NEEDLE_LOW,
        CFG_NEEDLE_HIGH,
        CFG_NEEDLE_LENGTH
    } t_cfg_index;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] match_start;
        logic             length_overflow;
    } t_result;

    typedef struct packed {
        logic    produce;
        logic    hit;
        t_result res;
    } t_step;

    function automatic logic [7:0] fold_case(input logic [7:0] b);
        logic [7:0] c;
        c = b;
        if (b >= 8'h41 && b <= 8'h5A) begin
            c = b + 8'd32;
        end
        return c;
    endfunction

endpackage

[sv/csf_in_if.sv]
// ----------------------------------------------------------------------------
// csf_in_if
// Haystack byte channel: one text byte and its end-of-haystack mark per item.
// ----------------------------------------------------------------------------
interface csf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       last_byte;

    modport source (output valid, output text_byte, output last_byte, input ready);
    modport sink   (input valid, input text_byte, input last_byte, output ready);
endinterface

[sv/csf_out_if.sv]
// ----------------------------------------------------------------------------
// csf_out_if
// Result channel: found flag, match offset and counter overflow flag.
// ----------------------------------------------------------------------------
interface csf_out_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [15:0] match_start;
    logic        length_overflow;

    modport source (output valid, output found, output match_start,
                    output length_overflow, input ready);
    modport sink   (input valid, input found, input match_start,
                    input length_overflow, output ready);
endinterface

[sv/csf_cfg.sv]
// ----------------------------------------------------------------------------
// csf_cfg
// Needle configuration registers; presents the folded needle and the
// clamped needle length.
// ----------------------------------------------------------------------------
module csf_cfg
    import csf_pkg::*;
#(
    parameter int NEEDLE_MAX = 16,
    parameter int LW         = $clog2(NEEDLE_MAX + 1)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data,
    output logic [NEEDLE_MAX*8-1:0] o_needle,
    output logic [LW-1:0]           o_len
);

    logic [CFG_DATA_W-1:0] r_low;
    logic [CFG_DATA_W-1:0] r_high;
    logic [LEN_REG_W-1:0]  r_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low  <= '0;
            r_high <= '0;
            r_len  <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_NEEDLE_LOW:    r_low  <= i_cfg_data;
                CFG_NEEDLE_HIGH:   r_high <= i_cfg_data;
                CFG_NEEDLE_LENGTH: r_len  <= i_cfg_data[LEN_REG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        logic [2*CFG_DATA_W-1:0] all_bytes;
        all_bytes = {r_high, r_low};
        for (int i = 0; i < NEEDLE_MAX; i++) begin
            if (i < NEEDLE_REG_BYTES) begin
                o_needle[i*8 +: 8] = fold_case(all_bytes[(i % NEEDLE_REG_BYTES)*8 +: 8]);
            end else begin
                o_needle[i*8 +: 8] = 8'h00;
            end
        end
    end

    // lengths above the window depth count as the full window
    assign o_len = (int'(r_len) > NEEDLE_MAX) ? LW'(NEEDLE_MAX) : LW'(r_len);

endmodule

[sv/csf_core.sv]
// ----------------------------------------------------------------------------
// csf_core
// Folded byte window, position counter and match flags; compares the window
// against the needle in parallel and updates the haystack state per item.
// ----------------------------------------------------------------------------
module csf_core
    import csf_pkg::*;
#(
    parameter int              NEEDLE_MAX   = 16,
    parameter longint unsigned HAYSTACK_MAX = 65536,
    parameter int              LW           = $clog2(NEEDLE_MAX + 1)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_adv,
    input  logic [7:0]              i_byte,
    input  logic                    i_last,
    input  logic [NEEDLE_MAX*8-1:0] i_needle,
    input  logic [LW-1:0]           i_len,
    output t_step                   o_step
);

    localparam int IW = (NEEDLE_MAX > 1) ? $clog2(NEEDLE_MAX) : 1;
    localparam logic [POS_W-1:0] CEIL =
        (HAYSTACK_MAX - 1 > 65535) ? 16'hFFFF : POS_W'(HAYSTACK_MAX - 1);

    logic [7:0]       r_win [NEEDLE_MAX];
    logic [7:0]       n_win [NEEDLE_MAX];
    logic [POS_W-1:0] r_pos;
    logic             r_sat;
    logic             r_reported;

    logic             all_ok;
    logic             hit;
    logic [POS_W:0]   pos_p1;
    logic [POS_W-1:0] match_start;

    always_comb begin
        logic [LW-1:0] jj;
        jj       = '0;
        n_win[0] = fold_case(i_byte);
        for (int k = 1; k < NEEDLE_MAX; k++) begin
            n_win[k] = r_win[k-1];
        end
        all_ok = 1'b1;
        // window slot k holds needle byte len-1-k
        for (int k = 0; k < NEEDLE_MAX; k++) begin
            jj = i_len - LW'(1) - LW'(k);
            if (LW'(k) < i_len && n_win[k] != i_needle[jj[IW-1:0]*8 +: 8]) begin
                all_ok = 1'b0;
            end
        end
    end

    assign pos_p1      = {1'b0, r_pos} + (POS_W+1)'(1);
    assign hit         = (i_len == '0) || ((pos_p1 >= (POS_W+1)'(i_len)) && all_ok);
    assign match_start = (i_len == '0) ? '0 : POS_W'(pos_p1 - (POS_W+1)'(i_len));

    always_comb begin
        o_step.produce             = !r_reported && (hit || i_last);
        o_step.hit                 = hit;
        o_step.res.found           = hit;
        o_step.res.match_start     = hit ? match_start : '0;
        o_step.res.length_overflow = r_sat;
    end

    always_ff @(posedge i_clk) begin
        if (i_adv && !r_reported) begin
            r_win <= n_win;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_sat      <= 1'b0;
            r_reported <= 1'b0;
        end else if (i_adv) begin
            if (i_last) begin
                r_pos      <= '0;
                r_sat      <= 1'b0;
                r_reported <= 1'b0;
            end else if (!r_reported) begin
                if (r_pos >= CEIL) begin
                    r_sat <= 1'b1;
                end else begin
                    r_pos <= r_pos + POS_W'(1);
                end
                if (hit) begin
                    r_reported <= 1'b1;
                end
            end
        end
    end

    a_sat_at_ceiling: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sat |-> (r_pos == CEIL))
        else $error("counter saturated below its ceiling");

    a_hit_latches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && !r_reported && hit && !i_last) |=> r_reported)
        else $error("first match not latched");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && i_last) |=> (r_pos == '0 && !r_sat && !r_reported))
        else $error("haystack state not cleared after last byte");

endmodule

[sv/caseless_substring_finder_top.sv]
// ----------------------------------------------------------------------------
// caseless_substring_finder_top
// Case-insensitive first-match substring search over a byte stream.
// ----------------------------------------------------------------------------
//  channel   dir  handshake           payload
//  i_text    in   valid/ready         text_byte[7:0], last_byte
//  o_res     out  valid/ready         found, match_start[15:0], length_overflow
//  cfg       in   i_cfg_we (no wait)  i_cfg_index[1:0], i_cfg_data[63:0]
//
//  one item per cycle sustained unless a result waits on a stalled o_res
//  one input register and one result register; window compare sits between
//  the input register holds one item while a result waits on o_res
//  synchronous active-low reset clears flow control and haystack state
// ----------------------------------------------------------------------------
module caseless_substring_finder_top
    import csf_pkg::*;
#(
    parameter int              NEEDLE_MAX   = 16,
    parameter longint unsigned HAYSTACK_MAX = 65536
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    csf_in_if.sink                 i_text,
    csf_out_if.source              o_res
);

    localparam int LW = $clog2(NEEDLE_MAX + 1);

    logic [NEEDLE_MAX*8-1:0] needle;
    logic [LW-1:0]           len;
    t_step                   step;

    logic       r_s1_valid;
    logic [7:0] r_s1_byte;
    logic       r_s1_last;
    logic       r_out_valid;
    t_result    r_out;

    logic s1_adv;
    logic in_ready;

    csf_cfg #(
        .NEEDLE_MAX (NEEDLE_MAX),
        .LW         (LW)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_needle    (needle),
        .o_len       (len)
    );

    csf_core #(
        .NEEDLE_MAX   (NEEDLE_MAX),
        .HAYSTACK_MAX (HAYSTACK_MAX),
        .LW           (LW)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (s1_adv),
        .i_byte   (r_s1_byte),
        .i_last   (r_s1_last),
        .i_needle (needle),
        .i_len    (len),
        .o_step   (step)
    );

    // stage 1 moves on unless its result has nowhere to go
    assign s1_adv   = r_s1_valid && (!step.produce || !r_out_valid || o_res.ready);
    assign in_ready = !r_s1_valid || s1_adv;

    assign i_text.ready = in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_ready) begin
                r_s1_valid <= i_text.valid;
            end
            if (s1_adv && step.produce) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_text.valid) begin
            r_s1_byte <= i_text.text_byte;
            r_s1_last <= i_text.last_byte;
        end
        if (s1_adv && step.produce) begin
            r_out <= step.res;
        end
    end

    assign o_res.valid           = r_out_valid;
    assign o_res.found           = r_out.found;
    assign o_res.match_start     = r_out.match_start;
    assign o_res.length_overflow = r_out.length_overflow;

endmodule
